/* src/assert_macros.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* src/lcdcp_pkg.sv */
`default_nettype none

package lcdcp_pkg;

    localparam int TEXT_COLUMNS    = 85;
    localparam int TEXT_ROWS       = 8;
    localparam int GRAPHIC_COLUMNS = 85;
    localparam int GRAPHIC_ROWS    = 64;
    localparam int GRAPHIC_BASE    = 8192;

    localparam int TEXT_SIZE = TEXT_COLUMNS * TEXT_ROWS;
    localparam int GFX_SIZE  = GRAPHIC_COLUMNS * GRAPHIC_ROWS;
    localparam int TEXT_AW   = (TEXT_SIZE > 1) ? $clog2(TEXT_SIZE) : 1;
    localparam int GFX_AW    = (GFX_SIZE > 1) ? $clog2(GFX_SIZE) : 1;
    localparam int CLR_SIZE  = (TEXT_SIZE > GFX_SIZE) ? TEXT_SIZE : GFX_SIZE;
    localparam int CLR_W     = (CLR_SIZE > 1) ? $clog2(CLR_SIZE) : 1;

    localparam int CURSOR_W   = 16;
    localparam int DATA_W     = 8;
    localparam int SIZE_W     = 3;
    localparam int ERR_W      = 2;
    localparam int IN_TDATA_W = 16;
    localparam int IN_TUSER_W = 2;
    localparam int OUT_TDATA_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
    localparam logic              REG_DATA  = 1'b0;
    localparam logic              REG_CMD   = 1'b1;
    localparam logic              ACC_READ  = 1'b0;
    localparam logic              ACC_WRITE = 1'b1;

    localparam logic [DATA_W-1:0] TEXT_FILL = 8'h20;
    localparam logic [DATA_W-1:0] GFX_FILL  = 8'h00;

    localparam logic [DATA_W-1:0] CMD_MWRITE   = 8'h42;
    localparam logic [DATA_W-1:0] CMD_MREAD    = 8'h43;
    localparam logic [DATA_W-1:0] CMD_CURSOR   = 8'h46;
    localparam logic [DATA_W-1:0] CMD_RIGHT    = 8'h4C;
    localparam logic [DATA_W-1:0] CMD_UP       = 8'h4E;
    localparam logic [DATA_W-1:0] CMD_DOWN     = 8'h4F;
    localparam logic [DATA_W-1:0] CMD_DISP_OFF = 8'h58;
    localparam logic [DATA_W-1:0] CMD_DISP_ON  = 8'h59;

    typedef enum logic [3:0] {
        OP_BAD,
        OP_READ,
        OP_ARG,
        OP_MWRITE,
        OP_MREAD,
        OP_CURSOR,
        OP_RIGHT,
        OP_UP,
        OP_DOWN,
        OP_DISP_OFF,
        OP_DISP_ON,
        OP_OTHER
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK     = 2'd0,
        ERR_ACCESS = 2'd1,
        ERR_CURSOR = 2'd2
    } t_err;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] data;
    } t_qent;

    typedef struct packed {
        logic  valid;
        logic  full;
        t_qent head;
    } t_qstat;

endpackage

`default_nettype wire

/* src/lcd_controller_command_port_top.sv */
// Each accepted item goes through the queue; its result is then registered in the output
// register, with a memory read passing through S_READ first, provided that register is free.
// Throughput: one item per cycle while the result register is free; a memory read holds
// the execute stage in S_READ: the text and graphics memories have a registered read port.
// Reset: synchronous, active low. After reset both memories are cleared in one pass over
// 5440 addresses (the graphics memory depth), during which s_axis_tready stays low.
`default_nettype none
`include "assert_macros.svh"

module lcd_controller_command_port_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // size_bytes [2:0], write_data [10:3], zero fill above
    input  logic [lcdcp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // command [0], reg_select [1]
    input  logic [lcdcp_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_data [7:0], display_on [8], zero fill above
    output logic [lcdcp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // error_code [1:0]
    output logic [lcdcp_pkg::ERR_W-1:0]        m_axis_tuser
);
    import lcdcp_pkg::*;

    logic   w_push;
    t_qent  w_entry;
    logic   w_pop;
    t_qstat w_qstat;
    logic   w_clearing;

    lcdcp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (w_qstat.full),
        .i_clearing    (w_clearing),
        .o_push        (w_push),
        .o_entry       (w_entry)
    );

    lcdcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_stat  (w_qstat)
    );

    lcdcp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .o_clearing    (w_clearing),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `ASSERT_NEVER(a_no_accept_in_clear, i_clk, i_rst_n, w_push && w_clearing, "accept in clear")
    `ASSERT_NEVER(a_queue_overflow, i_clk, i_rst_n, w_push && w_qstat.full, "queue overflow")
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, w_pop && !w_qstat.valid, "queue underflow")
    `ASSERT_IMPL(a_pop_free, i_clk, i_rst_n, w_pop, !m_axis_tvalid || m_axis_tready, "pop blocked")

endmodule

`default_nettype wire

/* src/lcdcp_front.sv */
`default_nettype none

module lcdcp_front (
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // size_bytes [2:0], write_data [10:3], zero fill above
    input  logic [lcdcp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // command [0], reg_select [1]
    input  logic [lcdcp_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    input  logic                                i_q_full,
    input  logic                                i_clearing,
    output logic                                o_push,
    output lcdcp_pkg::t_qent                    o_entry
);
    import lcdcp_pkg::*;

    logic [SIZE_W-1:0] w_size;
    logic [DATA_W-1:0] w_data;
    logic              w_access;
    logic              w_reg;
    t_op               w_cmd_op;

    assign w_size   = s_axis_tdata[SIZE_W-1:0];
    assign w_data   = s_axis_tdata[SIZE_W +: DATA_W];
    assign w_access = s_axis_tuser[0];
    assign w_reg    = s_axis_tuser[1];

    always_comb begin
        unique case (w_data)
            CMD_MWRITE:   w_cmd_op = OP_MWRITE;
            CMD_MREAD:    w_cmd_op = OP_MREAD;
            CMD_CURSOR:   w_cmd_op = OP_CURSOR;
            CMD_RIGHT:    w_cmd_op = OP_RIGHT;
            CMD_UP:       w_cmd_op = OP_UP;
            CMD_DOWN:     w_cmd_op = OP_DOWN;
            CMD_DISP_OFF: w_cmd_op = OP_DISP_OFF;
            CMD_DISP_ON:  w_cmd_op = OP_DISP_ON;
            default:      w_cmd_op = OP_OTHER;
        endcase
    end

    always_comb begin
        o_entry.data = w_data;
        priority if (w_size != SIZE_BYTE) begin
            o_entry.op = OP_BAD;
        end else if (w_access == ACC_WRITE && w_reg == REG_DATA) begin
            o_entry.op = OP_ARG;
        end else if (w_access == ACC_WRITE) begin
            o_entry.op = w_cmd_op;
        end else if (w_reg != REG_CMD) begin
            o_entry.op = OP_BAD;
        end else begin
            o_entry.op = OP_READ;
        end
    end

    // No item is taken while the memories are being cleared after reset.
    assign s_axis_tready = !i_q_full && !i_clearing;
    assign o_push        = s_axis_tvalid && s_axis_tready;

endmodule

`default_nettype wire

/* src/lcdcp_queue.sv */
`default_nettype none

module lcdcp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcdcp_pkg::t_qent  i_entry,
    input  logic              i_pop,
    output lcdcp_pkg::t_qstat o_stat
);
    import lcdcp_pkg::*;

    t_qent               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW-1:0] n_wr_ptr;
    logic [QUEUE_AW-1:0] n_rd_ptr;
    logic [QUEUE_AW:0]   n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_stat.head  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

/* src/lcdcp_back.sv */
`default_nettype none

module lcdcp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lcdcp_pkg::t_qstat                   i_qstat,
    output logic                                o_pop,
    output logic                                o_clearing,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_data [7:0], display_on [8], zero fill above
    output logic [lcdcp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // error_code [1:0]
    output logic [lcdcp_pkg::ERR_W-1:0]        m_axis_tuser
);
    import lcdcp_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_RUN   = 3'b010,
        S_READ  = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_MWRITE = 2'd1,
        MODE_MREAD  = 2'd2,
        MODE_CURSOR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STEP_RIGHT = 2'd0,
        STEP_UP    = 2'd1,
        STEP_DOWN  = 2'd2
    } t_dir;

    function automatic logic f_in_text(input logic [CURSOR_W-1:0] a);
        return 32'(a) < 32'(TEXT_SIZE);
    endfunction

    function automatic logic f_in_gfx(input logic [CURSOR_W-1:0] a);
        return (32'(a) >= 32'(GRAPHIC_BASE)) && (32'(a) < 32'(GRAPHIC_BASE + GFX_SIZE));
    endfunction

    logic [DATA_W-1:0] r_text_mem [TEXT_SIZE];
    logic [DATA_W-1:0] r_gfx_mem  [GFX_SIZE];
    logic [DATA_W-1:0] r_text_q;
    logic [DATA_W-1:0] r_gfx_q;

    t_state              r_state,     n_state;
    logic [CLR_W-1:0]    r_clr_idx,   n_clr_idx;
    t_mode               r_mode,      n_mode;
    logic [1:0]          r_argc,      n_argc;
    logic [CURSOR_W-1:0] r_cursor,    n_cursor;
    t_dir                r_dir,       n_dir;
    logic                r_disp,      n_disp;
    logic [1:0]          r_rd_sel,    n_rd_sel;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_rd,    n_out_rd;
    t_err                r_out_err,   n_out_err;
    logic                r_out_disp,  n_out_disp;

    logic                w_out_free;
    logic                w_cur_text;
    logic                w_cur_gfx;
    logic [CURSOR_W-1:0] w_gfx_off;
    logic [TEXT_AW-1:0]  w_text_idx;
    logic [GFX_AW-1:0]   w_gfx_idx;
    logic [CURSOR_W-1:0] w_step;
    logic [CURSOR_W-1:0] w_set_cursor;
    logic                w_set_bad;
    logic [DATA_W-1:0]   w_arg;
    logic                w_text_we;
    logic                w_gfx_we;
    logic [TEXT_AW-1:0]  w_text_waddr;
    logic [GFX_AW-1:0]   w_gfx_waddr;
    logic [DATA_W-1:0]   w_text_wdata;
    logic [DATA_W-1:0]   w_gfx_wdata;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign o_pop      = (r_state == S_RUN) && i_qstat.valid && w_out_free;
    assign o_clearing = (r_state == S_CLEAR);

    assign w_cur_text = f_in_text(r_cursor);
    assign w_cur_gfx  = f_in_gfx(r_cursor);
    assign w_gfx_off  = r_cursor - CURSOR_W'(GRAPHIC_BASE);
    assign w_text_idx = r_cursor[TEXT_AW-1:0];
    assign w_gfx_idx  = w_gfx_off[GFX_AW-1:0];
    assign w_arg      = i_qstat.head.data;

    always_comb begin
        unique case (r_dir)
            STEP_UP:   w_step = CURSOR_W'(32'h10000 - 32'(TEXT_COLUMNS));
            STEP_DOWN: w_step = CURSOR_W'(TEXT_COLUMNS);
            default:   w_step = CURSOR_W'(1);
        endcase
    end

    // The high cursor byte is merged over what the low byte left.
    assign w_set_cursor = {r_cursor[CURSOR_W-1:DATA_W] | w_arg, r_cursor[DATA_W-1:0]};
    assign w_set_bad    = !f_in_text(w_set_cursor) && !f_in_gfx(w_set_cursor);

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_mode       = r_mode;
        n_argc       = r_argc;
        n_cursor     = r_cursor;
        n_dir        = r_dir;
        n_disp       = r_disp;
        n_rd_sel     = r_rd_sel;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_rd     = r_out_rd;
        n_out_err    = r_out_err;
        n_out_disp   = r_out_disp;
        w_text_we    = 1'b0;
        w_gfx_we     = 1'b0;
        w_text_waddr = w_text_idx;
        w_gfx_waddr  = w_gfx_idx;
        w_text_wdata = w_arg;
        w_gfx_wdata  = w_arg;

        unique case (r_state)
            S_CLEAR: begin
                w_text_we    = (32'(r_clr_idx) < 32'(TEXT_SIZE));
                w_gfx_we     = (32'(r_clr_idx) < 32'(GFX_SIZE));
                w_text_waddr = r_clr_idx[TEXT_AW-1:0];
                w_gfx_waddr  = r_clr_idx[GFX_AW-1:0];
                w_text_wdata = TEXT_FILL;
                w_gfx_wdata  = GFX_FILL;
                if (r_clr_idx == CLR_W'(CLR_SIZE - 1)) begin
                    n_state = S_RUN;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            S_RUN: begin
                if (o_pop) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = '0;
                    n_out_err   = ERR_OK;
                    unique case (i_qstat.head.op)
                        OP_BAD: begin
                            n_out_err = ERR_ACCESS;
                        end
                        OP_READ: begin
                            // Memory data comes from the registered read and is taken in S_READ.
                            if (r_mode == MODE_MREAD) begin
                                n_out_valid = 1'b0;
                                n_rd_sel    = {w_cur_gfx, w_cur_text};
                                n_state     = S_READ;
                            end
                        end
                        OP_ARG: begin
                            if (r_argc != 2'd2) begin
                                n_argc = r_argc + 1'b1;
                            end
                            if (r_mode == MODE_MWRITE) begin
                                w_text_we = w_cur_text;
                                w_gfx_we  = !w_cur_text && w_cur_gfx;
                                n_cursor  = r_cursor + w_step;
                            end else if (r_mode == MODE_CURSOR) begin
                                if (r_argc == 2'd0) begin
                                    n_cursor = {{(CURSOR_W - DATA_W){1'b0}}, w_arg};
                                end else if (r_argc == 2'd1) begin
                                    n_cursor = w_set_cursor;
                                    if (w_set_bad) begin
                                        n_out_err = ERR_CURSOR;
                                    end
                                end
                            end
                        end
                        OP_MWRITE: begin
                            n_mode = MODE_MWRITE;
                            n_argc = '0;
                        end
                        OP_MREAD: begin
                            n_mode = MODE_MREAD;
                            n_argc = '0;
                        end
                        OP_CURSOR: begin
                            n_mode = MODE_CURSOR;
                            n_argc = '0;
                        end
                        OP_RIGHT: begin
                            n_dir  = STEP_RIGHT;
                            n_mode = MODE_NONE;
                            n_argc = '0;
                        end
                        OP_UP: begin
                            n_dir  = STEP_UP;
                            n_mode = MODE_NONE;
                            n_argc = '0;
                        end
                        OP_DOWN: begin
                            n_dir  = STEP_DOWN;
                            n_mode = MODE_NONE;
                            n_argc = '0;
                        end
                        OP_DISP_OFF: begin
                            n_disp = 1'b0;
                            n_mode = MODE_NONE;
                            n_argc = '0;
                        end
                        OP_DISP_ON: begin
                            n_disp = 1'b1;
                            n_mode = MODE_NONE;
                            n_argc = '0;
                        end
                        OP_OTHER: begin
                            n_mode = MODE_NONE;
                            n_argc = '0;
                        end
                        default: begin
                            n_out_err = ERR_ACCESS;
                        end
                    endcase
                    n_out_disp = n_disp;
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_out_err   = ERR_OK;
                n_out_disp  = r_disp;
                if (r_rd_sel[0]) begin
                    n_out_rd = r_text_q;
                end else if (r_rd_sel[1]) begin
                    n_out_rd = r_gfx_q;
                end else begin
                    n_out_rd = '0;
                end
                n_state = S_RUN;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_mode      <= MODE_NONE;
            r_argc      <= '0;
            r_cursor    <= '0;
            r_dir       <= STEP_RIGHT;
            r_disp      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_mode      <= n_mode;
            r_argc      <= n_argc;
            r_cursor    <= n_cursor;
            r_dir       <= n_dir;
            r_disp      <= n_disp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_sel   <= n_rd_sel;
        r_out_rd   <= n_out_rd;
        r_out_err  <= n_out_err;
        r_out_disp <= n_out_disp;
    end

    always_ff @(posedge i_clk) begin
        if (w_text_we) begin
            r_text_mem[w_text_waddr] <= w_text_wdata;
        end
        r_text_q <= r_text_mem[w_text_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_gfx_we) begin
            r_gfx_mem[w_gfx_waddr] <= w_gfx_wdata;
        end
        r_gfx_q <= r_gfx_mem[w_gfx_idx];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - DATA_W - 1){1'b0}}, r_out_disp, r_out_rd};
    assign m_axis_tuser  = r_out_err;

endmodule

`default_nettype wire
